@@ src/bwb_pkg.sv @@
// ----------------------------------------------------------------------------
// bwb_pkg
// shared types and constants for the bayer white balance gain unit
// ----------------------------------------------------------------------------
package bwb_pkg;

  localparam int NUM_LANES = 4;
  localparam int VALUE_W   = 8;
  localparam int GAIN_W    = 16;
  localparam int FRAC_BITS = 12;

  // lane indexes
  localparam int LANE_RED        = 0;
  localparam int LANE_GREEN_RED  = 1;
  localparam int LANE_BLUE       = 2;
  localparam int LANE_GREEN_BLUE = 3;

  // per-cycle commands from the sequencer to every lane
  typedef struct packed {
    logic accum;  // add the accepted sample value
    logic load;   // set up numerator and divisor, clear the sum
    logic start;  // first remainder and saturation check
    logic step;   // one quotient bit
  } lane_ctrl_t;

endpackage

@@ src/bwb_lane.sv @@
// ----------------------------------------------------------------------------
// bwb_lane
// one color channel: saturating sum and a bit-serial gain divider
// ----------------------------------------------------------------------------
module bwb_lane #(
  parameter int SUM_W     = 18,
  parameter int SUM_LIMIT = 261120
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bwb_pkg::lane_ctrl_t         ctrl,
  input  logic [bwb_pkg::VALUE_W-1:0] value,
  input  logic [SUM_W-1:0]            peak,
  output logic [SUM_W-1:0]            sum,
  output logic [bwb_pkg::GAIN_W-1:0]  gain
);

  localparam int NUM_W = SUM_W + bwb_pkg::FRAC_BITS + 2;
  localparam int HI_W  = NUM_W - bwb_pkg::GAIN_W;
  localparam int R_W   = SUM_W + 2;
  localparam int D_W   = SUM_W + 1;

  logic [SUM_W-1:0]           acc;
  logic [SUM_W:0]             acc_add;
  logic [NUM_W-1:0]           num;
  logic [HI_W-1:0]            num_hi;
  logic [bwb_pkg::GAIN_W-1:0] quo;
  logic [D_W-1:0]             div;
  logic [R_W-1:0]             rem;
  logic [R_W-1:0]             trial;
  logic                       sat;

  assign acc_add = (SUM_W+1)'(acc) + (SUM_W+1)'(value);
  assign num     = (NUM_W'(peak) << (bwb_pkg::FRAC_BITS + 1)) + NUM_W'(acc);
  assign trial   = {rem[R_W-2:0], quo[bwb_pkg::GAIN_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.load) begin
      acc <= '0;
    end else if (ctrl.accum) begin
      if (acc_add > (SUM_W+1)'(SUM_LIMIT)) begin
        acc <= SUM_W'(SUM_LIMIT);
      end else begin
        acc <= acc_add[SUM_W-1:0];
      end
    end
  end

  // restoring division, quotient bits shift into the low numerator word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num_hi <= num[NUM_W-1:bwb_pkg::GAIN_W];
      quo    <= num[bwb_pkg::GAIN_W-1:0];
      div    <= {acc, 1'b0};
    end else if (ctrl.start) begin
      sat <= R_W'(num_hi) >= R_W'(div);
      rem <= R_W'(num_hi);
    end else if (ctrl.step) begin
      if (trial >= R_W'(div)) begin
        rem <= trial - R_W'(div);
        quo <= {quo[bwb_pkg::GAIN_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[bwb_pkg::GAIN_W-2:0], 1'b0};
      end
    end
  end

  assign sum  = acc;
  assign gain = sat ? '1 : quo;

endmodule

@@ src/bwb_merge.sv @@
// ----------------------------------------------------------------------------
// bwb_merge
// combines the lane sums: largest sum and all-nonzero flag, registered
// ----------------------------------------------------------------------------
module bwb_merge #(
  parameter int SUM_W = 18
) (
  input  logic             clk,
  input  logic             capture,
  input  logic [SUM_W-1:0] sums [bwb_pkg::NUM_LANES],
  output logic [SUM_W-1:0] peak,
  output logic             all_nonzero
);

  logic [SUM_W-1:0] max_a;
  logic [SUM_W-1:0] max_b;
  logic             any_zero;

  assign max_a = (sums[bwb_pkg::LANE_RED] > sums[bwb_pkg::LANE_GREEN_RED]) ?
                 sums[bwb_pkg::LANE_RED] : sums[bwb_pkg::LANE_GREEN_RED];
  assign max_b = (sums[bwb_pkg::LANE_BLUE] > sums[bwb_pkg::LANE_GREEN_BLUE]) ?
                 sums[bwb_pkg::LANE_BLUE] : sums[bwb_pkg::LANE_GREEN_BLUE];

  always_comb begin
    any_zero = 1'b0;
    for (int i = 0; i < bwb_pkg::NUM_LANES; i++) begin
      any_zero = any_zero | (sums[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      peak        <= (max_a > max_b) ? max_a : max_b;
      all_nonzero <= ~any_zero;
    end
  end

endmodule

@@ src/bayer_white_balance_gains.sv @@
// ----------------------------------------------------------------------------
// bayer_white_balance_gains
// gray-world white balance gains from a run of bayer sample points
// ----------------------------------------------------------------------------
// throughput: one sample per cycle inside a set; after the last sample the input stalls
//   through peak capture, divider setup, the 16-step radix-2 divider in each lane and
//   the hand-off to the output register, which waits while the output is stalled
// reset: clears all channel sums, returns to accumulation, empties the output
// ----------------------------------------------------------------------------
module bayer_white_balance_gains #(
  parameter int MAX_SAMPLE_POINTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red_value,
  input  logic [7:0]  green_red_value,
  input  logic [7:0]  blue_value,
  input  logic [7:0]  green_blue_value,
  input  logic        last_sample,
  // gain channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        gains_valid,
  output logic [15:0] gain_red,
  output logic [15:0] gain_green_red,
  output logic [15:0] gain_blue,
  output logic [15:0] gain_green_blue
);

  // largest sum a legal set can reach, and the sum width that holds it
  localparam int SUM_LIMIT = MAX_SAMPLE_POINTS * 255;
  localparam int SUM_W     = $clog2(SUM_LIMIT + 1);
  localparam int CNT_W     = $clog2(bwb_pkg::GAIN_W);

  // sequencer states
  localparam logic [2:0] ST_ACCUM = 3'd0;  // taking samples
  localparam logic [2:0] ST_PEAK  = 3'd1;  // merge stage captures peak
  localparam logic [2:0] ST_LOAD  = 3'd2;  // lanes set up their dividers
  localparam logic [2:0] ST_START = 3'd3;  // saturation check
  localparam logic [2:0] ST_DIV   = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] ST_DONE  = 3'd5;  // hand gains to output register

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] step_cnt;

  logic                        in_fire;
  logic                        out_load;
  bwb_pkg::lane_ctrl_t         ctrl;
  logic [bwb_pkg::VALUE_W-1:0] lane_value [bwb_pkg::NUM_LANES];
  logic [SUM_W-1:0]            lane_sum   [bwb_pkg::NUM_LANES];
  logic [bwb_pkg::GAIN_W-1:0]  lane_gain  [bwb_pkg::NUM_LANES];
  logic [SUM_W-1:0]            peak;
  logic                        all_nonzero;

  assign in_ready = (state == ST_ACCUM);
  assign in_fire  = in_valid & in_ready;
  // output register frees up in the same cycle it is taken
  assign out_load = (state == ST_DONE) & (~out_valid | out_ready);

  assign ctrl.accum = in_fire;
  assign ctrl.load  = (state == ST_LOAD);
  assign ctrl.start = (state == ST_START);
  assign ctrl.step  = (state == ST_DIV);

  assign lane_value[bwb_pkg::LANE_RED]        = red_value;
  assign lane_value[bwb_pkg::LANE_GREEN_RED]  = green_red_value;
  assign lane_value[bwb_pkg::LANE_BLUE]       = blue_value;
  assign lane_value[bwb_pkg::LANE_GREEN_BLUE] = green_blue_value;

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (in_fire && last_sample) begin
          state_next = ST_PEAK;
        end
      end
      ST_PEAK:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (step_cnt == CNT_W'(bwb_pkg::GAIN_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_ACCUM;
        end
      end
      default:  state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACCUM;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // one lane per color channel
  for (genvar g = 0; g < bwb_pkg::NUM_LANES; g++) begin : g_lane
    bwb_lane #(
      .SUM_W     (SUM_W),
      .SUM_LIMIT (SUM_LIMIT)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .value (lane_value[g]),
      .peak  (peak),
      .sum   (lane_sum[g]),
      .gain  (lane_gain[g])
    );
  end

  // largest sum and zero check across lanes
  bwb_merge #(
    .SUM_W (SUM_W)
  ) u_merge (
    .clk         (clk),
    .capture     (state == ST_PEAK),
    .sums        (lane_sum),
    .peak        (peak),
    .all_nonzero (all_nonzero)
  );

  // output register, a zero sum anywhere forces zero gains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gains_valid     <= all_nonzero;
      gain_red        <= all_nonzero ? lane_gain[bwb_pkg::LANE_RED]        : '0;
      gain_green_red  <= all_nonzero ? lane_gain[bwb_pkg::LANE_GREEN_RED]  : '0;
      gain_blue       <= all_nonzero ? lane_gain[bwb_pkg::LANE_BLUE]       : '0;
      gain_green_blue <= all_nonzero ? lane_gain[bwb_pkg::LANE_GREEN_BLUE] : '0;
    end
  end

endmodule

@@ src/bwb_checker.sv @@
// ----------------------------------------------------------------------------
// bwb_checker
// port-level checks for the white balance gain unit
// ----------------------------------------------------------------------------
module bwb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_sample,
  input logic        out_valid,
  input logic        out_ready,
  input logic        gains_valid,
  input logic [15:0] gain_red,
  input logic [15:0] gain_green_red,
  input logic [15:0] gain_blue,
  input logic [15:0] gain_green_blue
);

  localparam logic [15:0] UNITY = 16'h1000;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(gains_valid) && $stable(gain_red)
      && $stable(gain_green_red) && $stable(gain_blue) && $stable(gain_green_blue))
    else $error("result changed while stalled");

  // invalid result carries zero gains
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !gains_valid |-> gain_red == '0 && gain_green_red == '0
      && gain_blue == '0 && gain_green_blue == '0)
    else $error("invalid result with nonzero gain");

  // in a valid result the peak channel has unity gain
  a_unity_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && gains_valid |-> gain_red == UNITY || gain_green_red == UNITY
      || gain_blue == UNITY || gain_green_blue == UNITY)
    else $error("no channel at unity gain");

  // the end of a set stalls the sample channel while gains are computed
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> !in_ready)
    else $error("sample accepted during gain computation");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bayer_white_balance_gains bwb_checker u_bwb_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .last_sample     (last_sample),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .gains_valid     (gains_valid),
  .gain_red        (gain_red),
  .gain_green_red  (gain_green_red),
  .gain_blue       (gain_blue),
  .gain_green_blue (gain_green_blue)
);
